@@ rtl/core/sbf_pkg.sv @@
// shared types, constants and font tables of the scaled bitmap font pixel generator
package sbf_pkg;

  // font geometry
  localparam int GLYPH_COLS = 5;
  localparam int GLYPH_ROWS = 7;
  localparam int GLYPH_BITS = GLYPH_COLS * GLYPH_ROWS;
  localparam int GLYPH_COUNT = 47;
  localparam int SBF_MAX_FONT_HEIGHT = 64;
  localparam logic [6:0] MIN_FONT_HEIGHT = 7'd7;

  // register indexes of the configuration port
  localparam logic REG_FONT_HEIGHT = 1'b0;
  localparam logic REG_BOLD_MODE = 1'b1;

  // character codes with special font entries
  localparam logic [7:0] ASC_ZERO = "0";
  localparam logic [7:0] ASC_NINE = "9";
  localparam logic [7:0] ASC_UP_C = "C";
  localparam logic [7:0] ASC_UP_P = "P";
  localparam logic [7:0] ASC_UP_F = "F";
  localparam logic [7:0] ASC_UP_S = "S";
  localparam logic [7:0] ASC_COLON = ":";
  localparam logic [7:0] ASC_DOT = ".";
  localparam logic [7:0] ASC_MINUS = "-";
  localparam logic [7:0] ASC_SPACE = " ";
  localparam logic [7:0] ASC_UP_A = "A";
  localparam logic [7:0] ASC_UP_Z = "Z";
  localparam logic [7:0] ASC_LO_A = "a";
  localparam logic [7:0] ASC_LO_Z = "z";
  localparam logic [7:0] ASC_HASH = "#";
  localparam logic [7:0] ASC_LBRACKET = "[";
  localparam logic [7:0] ASC_RBRACKET = "]";

  // glyph slots in the font
  localparam logic [5:0] GL_C = 6'd10;
  localparam logic [5:0] GL_P = 6'd11;
  localparam logic [5:0] GL_F = 6'd12;
  localparam logic [5:0] GL_S = 6'd13;
  localparam logic [5:0] GL_COLON = 6'd14;
  localparam logic [5:0] GL_DOT = 6'd15;
  localparam logic [5:0] GL_MINUS = 6'd16;
  localparam logic [5:0] GL_BLANK = 6'd17;
  localparam logic [5:0] GL_LOWER_A = 6'd18;
  localparam logic [5:0] GL_HASH = 6'd44;
  localparam logic [5:0] GL_LBRACKET = 6'd45;
  localparam logic [5:0] GL_RBRACKET = 6'd46;

  typedef struct packed {
    logic       known;
    logic [5:0] idx;
  } entry_t;

  // scale values derived from the configuration
  typedef struct packed {
    logic [6:0] h;
    logic [5:0] gw;
    logic [2:0] bo;
    logic [5:0] adv;
  } scale_t;

  // band thresholds: row bands 1..6, column bands 1..4
  typedef logic [GLYPH_ROWS-2:0][5:0] row_thr_t;
  typedef logic [GLYPH_COLS-2:0][5:0] col_thr_t;

  // floor(x / 7) by reciprocal, exact for x below 448 (6-bit result)
  function automatic logic [5:0] div7(input logic [8:0] x);
    logic [17:0] p;
    p = 18'(x) * 18'd293;
    return p[16:11];
  endfunction

  // floor(x / 5) by reciprocal, exact for every 8-bit x
  function automatic logic [5:0] div5(input logic [7:0] x);
    logic [17:0] p;
    p = 18'(x) * 18'd205;
    return p[15:10];
  endfunction

  // character code to font slot, uppercase folded except C, P, F, S
  function automatic entry_t entry_of(input logic [7:0] code);
    entry_t e;
    e.known = 1'b1;
    e.idx = GL_BLANK;
    case (code) inside
      [ASC_ZERO:ASC_NINE]: e.idx = 6'(code - ASC_ZERO);
      ASC_UP_C: e.idx = GL_C;
      ASC_UP_P: e.idx = GL_P;
      ASC_UP_F: e.idx = GL_F;
      ASC_UP_S: e.idx = GL_S;
      ASC_COLON: e.idx = GL_COLON;
      ASC_DOT: e.idx = GL_DOT;
      ASC_MINUS: e.idx = GL_MINUS;
      ASC_SPACE: e.idx = GL_BLANK;
      [ASC_UP_A:ASC_UP_Z]: e.idx = 6'(code - ASC_UP_A) + GL_LOWER_A;
      [ASC_LO_A:ASC_LO_Z]: e.idx = 6'(code - ASC_LO_A) + GL_LOWER_A;
      ASC_HASH: e.idx = GL_HASH;
      ASC_LBRACKET: e.idx = GL_LBRACKET;
      ASC_RBRACKET: e.idx = GL_RBRACKET;
      default: e.known = 1'b0;
    endcase
    return e;
  endfunction

  // 5x7 glyph bitmap, row 0 in the top bits, column 0 as msb of each row
  function automatic logic [GLYPH_BITS-1:0] glyph_rows(input logic [5:0] idx);
    logic [GLYPH_BITS-1:0] g;
    case (idx)
      6'd0:  g = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
      6'd1:  g = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
      6'd2:  g = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
      6'd3:  g = {5'h1F, 5'h02, 5'h04, 5'h02, 5'h01, 5'h11, 5'h0E};
      6'd4:  g = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
      6'd5:  g = {5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E};
      6'd6:  g = {5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
      6'd7:  g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
      6'd8:  g = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
      6'd9:  g = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C};
      6'd10: g = {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E};
      6'd11: g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
      6'd12: g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
      6'd13: g = {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
      6'd14: g = {5'h00, 5'h04, 5'h00, 5'h00, 5'h04, 5'h04, 5'h00};
      6'd15: g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h0C, 5'h0C};
      6'd16: g = {5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00};
      6'd17: g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00};
      6'd18: g = {5'h0E, 5'h11, 5'h01, 5'h0F, 5'h11, 5'h11, 5'h0F};
      6'd19: g = {5'h10, 5'h10, 5'h16, 5'h19, 5'h11, 5'h19, 5'h16};
      6'd20: g = {5'h00, 5'h00, 5'h0E, 5'h10, 5'h10, 5'h10, 5'h0E};
      6'd21: g = {5'h01, 5'h01, 5'h0D, 5'h13, 5'h11, 5'h13, 5'h0D};
      6'd22: g = {5'h00, 5'h00, 5'h0E, 5'h11, 5'h1F, 5'h10, 5'h0E};
      6'd23: g = {5'h06, 5'h08, 5'h08, 5'h1E, 5'h08, 5'h08, 5'h08};
      6'd24: g = {5'h00, 5'h0F, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h0E};
      6'd25: g = {5'h10, 5'h10, 5'h16, 5'h19, 5'h11, 5'h11, 5'h11};
      6'd26: g = {5'h04, 5'h00, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h0E};
      6'd27: g = {5'h02, 5'h00, 5'h06, 5'h02, 5'h02, 5'h12, 5'h0C};
      6'd28: g = {5'h10, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
      6'd29: g = {5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
      6'd30: g = {5'h00, 5'h00, 5'h1A, 5'h15, 5'h15, 5'h15, 5'h15};
      6'd31: g = {5'h00, 5'h00, 5'h16, 5'h19, 5'h11, 5'h11, 5'h11};
      6'd32: g = {5'h00, 5'h00, 5'h0E, 5'h11, 5'h11, 5'h11, 5'h0E};
      6'd33: g = {5'h00, 5'h00, 5'h1E, 5'h11, 5'h1E, 5'h10, 5'h10};
      6'd34: g = {5'h00, 5'h00, 5'h0D, 5'h13, 5'h0F, 5'h01, 5'h01};
      6'd35: g = {5'h00, 5'h00, 5'h16, 5'h19, 5'h10, 5'h10, 5'h10};
      6'd36: g = {5'h00, 5'h00, 5'h0F, 5'h10, 5'h0E, 5'h01, 5'h1E};
      6'd37: g = {5'h08, 5'h08, 5'h1E, 5'h08, 5'h08, 5'h09, 5'h06};
      6'd38: g = {5'h00, 5'h00, 5'h11, 5'h11, 5'h11, 5'h13, 5'h0D};
      6'd39: g = {5'h00, 5'h00, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04};
      6'd40: g = {5'h00, 5'h00, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0A};
      6'd41: g = {5'h00, 5'h00, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11};
      6'd42: g = {5'h00, 5'h00, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h0E};
      6'd43: g = {5'h00, 5'h00, 5'h1F, 5'h02, 5'h04, 5'h08, 5'h1F};
      6'd44: g = {5'h0A, 5'h0A, 5'h1F, 5'h0A, 5'h1F, 5'h0A, 5'h0A};
      6'd45: g = {5'h0E, 5'h08, 5'h08, 5'h08, 5'h08, 5'h08, 5'h0E};
      6'd46: g = {5'h0E, 5'h02, 5'h02, 5'h02, 5'h02, 5'h02, 5'h0E};
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

@@ rtl/core/sbf_if.sv @@
// valid/ready channel interfaces for character pixel requests and results
interface sbf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic [5:0] cell_column;
  logic [6:0] cell_row;

  modport source (output valid, output char_code, output cell_column, output cell_row,
                  input ready);
  modport sink (input valid, input char_code, input cell_column, input cell_row,
                output ready);
endinterface

interface sbf_out_if;
  logic       valid;
  logic       ready;
  logic       pixel_lit;
  logic       glyph_known;
  logic [5:0] cell_advance;

  modport source (output valid, output pixel_lit, output glyph_known, output cell_advance,
                  input ready);
  modport sink (input valid, input pixel_lit, input glyph_known, input cell_advance,
                output ready);
endinterface

@@ rtl/core/sbf_scale.sv @@
// font scale derivation: clamped height, glyph width, bold offset and cell advance
module sbf_scale
  import sbf_pkg::*;
#(
  parameter int MAX_FONT_HEIGHT = SBF_MAX_FONT_HEIGHT
) (
  input  logic [6:0] font_height,
  input  logic       bold_mode,
  output scale_t     scale
);

  logic [6:0] h;
  logic [5:0] gw;
  logic [5:0] sp;
  logic [5:0] bo_full;
  logic [2:0] bo;
  logic [6:0] hb;

  // clamp height into the supported range
  always_comb begin
    if (font_height < MIN_FONT_HEIGHT) begin
      h = MIN_FONT_HEIGHT;
    end else if (font_height > 7'(MAX_FONT_HEIGHT)) begin
      h = 7'(MAX_FONT_HEIGHT);
    end else begin
      h = font_height;
    end
  end

  // glyph width 5h/7 rounded up, spacing h/7 rounded up, bold h/14 rounded up
  assign gw = div7(9'(h) * 9'd5 + 9'd6);
  assign sp = div7(9'(h) + 9'd6);
  assign hb = (h + 7'd13) >> 1;
  assign bo_full = div7(9'(hb));
  assign bo = bold_mode ? bo_full[2:0] : 3'd0;

  assign scale.h = h;
  assign scale.gw = gw;
  assign scale.bo = bo;
  assign scale.adv = gw + sp + 6'(bo);

endmodule

@@ rtl/core/scaled_bitmap_font_pixel_generator.sv @@
// top level: four-stage pixel pipeline of the scaled 5x7 osd character generator
// path: a word accepted from in_ch is registered in s1, s2, s3 and s4, and leaves out_ch from s4
// throughput: one word per cycle while out_ch is ready; a stage holds its word only while the next one is stalled
// the depth is set by the capture, threshold, band and glyph-bit stages between input and output
// reset (rst_n low at a clock edge): all stages empty, font_height 7, bold_mode 0
module scaled_bitmap_font_pixel_generator
  import sbf_pkg::*;
#(
  parameter int MAX_FONT_HEIGHT = SBF_MAX_FONT_HEIGHT
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [6:0] cfg_wdata,
  sbf_in_if.sink     in_ch,
  sbf_out_if.source  out_ch
);

  // largest bold offset reachable at the top font height
  localparam int BOLD_MAX = (MAX_FONT_HEIGHT + 13) / 14;

  // configuration registers
  logic [6:0] font_height_r;
  logic       bold_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      font_height_r <= MIN_FONT_HEIGHT;
      bold_mode_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FONT_HEIGHT: font_height_r <= cfg_wdata;
        REG_BOLD_MODE:   bold_mode_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  scale_t scale;

  sbf_scale #(
    .MAX_FONT_HEIGHT(MAX_FONT_HEIGHT)
  ) u_scale (
    .font_height(font_height_r),
    .bold_mode(bold_mode_r),
    .scale(scale)
  );

  // band index of a coordinate: how many thresholds it has reached
  function automatic logic [2:0] row_band(input logic [6:0] x, input row_thr_t t);
    logic [2:0] n;
    n = '0;
    for (int k = 0; k < GLYPH_ROWS - 1; k++) begin
      if (x >= {1'b0, t[k]}) n = n + 3'd1;
    end
    return n;
  endfunction

  function automatic logic [2:0] col_band(input logic [6:0] x, input col_thr_t u);
    logic [2:0] n;
    n = '0;
    for (int k = 0; k < GLYPH_COLS - 1; k++) begin
      if (x >= {1'b0, u[k]}) n = n + 3'd1;
    end
    return n;
  endfunction

  function automatic logic glyph_bit(input logic [GLYPH_BITS-1:0] g, input logic [2:0] r,
                                     input logic [2:0] c);
    logic [5:0] i;
    i = 6'(GLYPH_BITS - 1) - 6'(r) * 6'(GLYPH_COLS) - 6'(c);
    return g[i];
  endfunction

  // pipeline registers
  logic                  s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic                  en1, en2, en3, en4;

  entry_t                s1_ent_r;
  logic [5:0]            s1_col_r;
  logic [6:0]            s1_row_r;
  scale_t                s1_sc_r;

  logic                  s2_known_r;
  logic [GLYPH_BITS-1:0] s2_glyph_r, s2_glyph_nxt;
  logic [5:0]            s2_col_r;
  logic [6:0]            s2_row_r;
  scale_t                s2_sc_r;
  row_thr_t              s2_t_r, s2_t_nxt;
  col_thr_t              s2_u_r, s2_u_nxt;

  logic                  s3_known_r;
  logic [GLYPH_BITS-1:0] s3_glyph_r;
  logic [5:0]            s3_adv_r;
  logic [BOLD_MAX:0]     s3_hv_r, s3_hv_nxt;
  logic [2:0]            s3_hsc_r [BOLD_MAX+1];
  logic [2:0]            s3_hsc_nxt [BOLD_MAX+1];
  logic [2:0]            s3_sr0_r, s3_sr0_nxt;
  logic [BOLD_MAX:1]     s3_vv_r, s3_vv_nxt;
  logic [2:0]            s3_vsr_r [1:BOLD_MAX];
  logic [2:0]            s3_vsr_nxt [1:BOLD_MAX];

  logic                  s4_lit_r, s4_lit_nxt;
  logic                  s4_known_r;
  logic [5:0]            s4_adv_r;

  // stall chain: a stage moves when it is empty or the next one moves
  assign en4 = !s4_v_r || out_ch.ready;
  assign en3 = !s3_v_r || en4;
  assign en2 = !s2_v_r || en3;
  assign en1 = !s1_v_r || en2;
  assign in_ch.ready = en1;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      if (en1) s1_v_r <= in_ch.valid;
      if (en2) s2_v_r <= s1_v_r;
      if (en3) s3_v_r <= s2_v_r;
      if (en4) s4_v_r <= s3_v_r;
    end
  end

  // stage 1: capture word, look up font slot and scale
  always_ff @(posedge clk) begin
    if (en1) begin
      s1_ent_r <= entry_of(in_ch.char_code);
      s1_col_r <= in_ch.cell_column;
      s1_row_r <= in_ch.cell_row;
      s1_sc_r <= scale;
    end
  end

  // stage 2: band thresholds ceil(k*h/7), ceil(k*gw/5) and glyph fetch
  always_comb begin
    for (int k = 0; k < GLYPH_ROWS - 1; k++) begin
      s2_t_nxt[k] = div7(9'(s1_sc_r.h) * 9'(k + 1) + 9'd6);
    end
    for (int k = 0; k < GLYPH_COLS - 1; k++) begin
      s2_u_nxt[k] = div5(8'(s1_sc_r.gw) * 8'(k + 1) + 8'd4);
    end
    s2_glyph_nxt = s1_ent_r.known ? glyph_rows(s1_ent_r.idx) : '0;
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_known_r <= s1_ent_r.known;
      s2_glyph_r <= s2_glyph_nxt;
      s2_col_r <= s1_col_r;
      s2_row_r <= s1_row_r;
      s2_sc_r <= s1_sc_r;
      s2_t_r <= s2_t_nxt;
      s2_u_r <= s2_u_nxt;
    end
  end

  // stage 3: font bands of the pixel and of its bold neighbors left and above
  always_comb begin
    logic [6:0] c;
    logic [6:0] r;
    logic       row_in;
    logic       col_in;
    row_in = s2_row_r < s2_sc_r.h;
    col_in = {1'b0, s2_col_r} < {1'b0, s2_sc_r.gw};
    s3_sr0_nxt = row_band(s2_row_r, s2_t_r);
    for (int o = 0; o <= BOLD_MAX; o++) begin
      c = {1'b0, s2_col_r} - 7'(o);
      s3_hv_nxt[o] = ({1'b0, s2_col_r} >= 7'(o)) && (3'(o) <= s2_sc_r.bo) &&
                     (c < {1'b0, s2_sc_r.gw}) && row_in;
      s3_hsc_nxt[o] = col_band(c, s2_u_r);
    end
    for (int o = 1; o <= BOLD_MAX; o++) begin
      r = s2_row_r - 7'(o);
      s3_vv_nxt[o] = (s2_row_r >= 7'(o)) && (3'(o) <= s2_sc_r.bo) &&
                     (r < s2_sc_r.h) && col_in;
      s3_vsr_nxt[o] = row_band(r, s2_t_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_known_r <= s2_known_r;
      s3_glyph_r <= s2_glyph_r;
      s3_adv_r <= s2_sc_r.adv;
      s3_hv_r <= s3_hv_nxt;
      s3_hsc_r <= s3_hsc_nxt;
      s3_sr0_r <= s3_sr0_nxt;
      s3_vv_r <= s3_vv_nxt;
      s3_vsr_r <= s3_vsr_nxt;
    end
  end

  // stage 4: pick glyph bits and merge the bold smear
  always_comb begin
    s4_lit_nxt = 1'b0;
    for (int o = 0; o <= BOLD_MAX; o++) begin
      if (s3_hv_r[o] && glyph_bit(s3_glyph_r, s3_sr0_r, s3_hsc_r[o])) s4_lit_nxt = 1'b1;
    end
    for (int o = 1; o <= BOLD_MAX; o++) begin
      if (s3_vv_r[o] && glyph_bit(s3_glyph_r, s3_vsr_r[o], s3_hsc_r[0])) s4_lit_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_lit_r <= s4_lit_nxt;
      s4_known_r <= s3_known_r;
      s4_adv_r <= s3_adv_r;
    end
  end

  // result word
  assign out_ch.valid = s4_v_r;
  assign out_ch.pixel_lit = s4_lit_r;
  assign out_ch.glyph_known = s4_known_r;
  assign out_ch.cell_advance = s4_adv_r;

`ifndef ASSERT_OFF
  // an unknown character never paints a pixel
  a_unknown_blank: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.glyph_known |-> !out_ch.pixel_lit)
    else $error("unknown glyph produced a lit pixel");

  // a full pipeline with a stalled output takes no new word
  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && s2_v_r && s3_v_r && s4_v_r && !out_ch.ready |-> !in_ch.ready)
    else $error("input accepted while pipeline full and stalled");

  // a word leaving stage 3 shows up at the output on the next cycle
  a_stage3_moves: assert property (@(posedge clk) disable iff (!rst_n)
    s3_v_r && en4 |=> out_ch.valid)
    else $error("word lost between stage 3 and output");

  // a stalled result keeps its advance
  a_adv_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> $stable(s4_adv_r))
    else $error("cell advance changed while stalled");
`endif

endmodule
